/* src/caa_pkg.sv */
// Shared types and constants for the coolant alarm annunciator.
`default_nettype none
package caa_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_BLINK = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		SND_SILENT  = 3'd0,
		SND_SINGLE  = 3'd1,
		SND_DOUBLE  = 3'd2,
		SND_TRIPLE  = 3'd3,
		SND_BUS_ERR = 3'd4,
		SND_CHIME   = 3'd5,
		SND_START   = 3'd6
	} sound_mode_t;

	typedef enum logic [1:0] {
		LED_OFF    = 2'd0,
		LED_BLINK  = 2'd1,
		LED_STEADY = 2'd2,
		LED_SINGLE = 2'd3
	} led_mode_t;

	typedef enum logic {
		REG_WARMUP = 1'b0,
		REG_FAN    = 1'b1
	} reg_idx_t;

	localparam int TEMP_W  = 9;
	localparam int TONE_W  = 11;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic signed [TEMP_W-1:0] WARMUP_RESET = 9'sd45;
	localparam logic signed [TEMP_W-1:0] FAN_RESET    = 9'sd98;

	localparam logic [TONE_W-1:0] TONE_SINGLE  = 11'd1838;
	localparam logic [TONE_W-1:0] TONE_DOUBLE  = 11'd1919;
	localparam logic [TONE_W-1:0] TONE_TRIPLE  = 11'd2004;
	localparam logic [TONE_W-1:0] TONE_BUS_ERR = 11'd300;
	localparam logic [TONE_W-1:0] TONE_START   = 11'd1500;
	localparam logic [TONE_W-1:0] TONE_CHIME1  = 11'd1600;
	localparam logic [TONE_W-1:0] TONE_CHIME2  = 11'd1700;
	localparam logic [TONE_W-1:0] TONE_CHIME3  = 11'd1800;

	localparam logic [5:0] WAIT_BEEP         = 6'd2;
	localparam logic [5:0] WAIT_GAP          = 6'd1;
	localparam logic [5:0] WAIT_SINGLE_PAUSE = 6'd40;
	localparam logic [5:0] WAIT_DOUBLE_PAUSE = 6'd37;
	localparam logic [5:0] WAIT_TRIPLE_PAUSE = 6'd20;
	localparam logic [5:0] WAIT_ERR_PAUSE    = 6'd20;
	localparam logic [5:0] WAIT_ERR_BEEP     = 6'd1;
	localparam logic [3:0] LED_HALF_PERIOD   = 4'd8;
	localparam logic [3:0] LED_FLASH         = 4'd1;

	typedef struct packed {
		sound_mode_t              sound_mode;
		led_mode_t                led_mode;
		logic [2:0]               pulse_index;
		logic [5:0]               sound_wait;
		logic [3:0]               led_wait;
		logic signed [TEMP_W-1:0] prev_temp;
		logic                     buzzer;
		logic [TONE_W-1:0]        tone;
		logic                     led;
	} caa_state_t;

	typedef struct packed {
		action_t                  action;
		logic signed [TEMP_W-1:0] coolant_temp;
		logic                     bus_error;
		logic                     cycle_active;
	} caa_item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] warmup_temp;
		logic signed [TEMP_W-1:0] fan_temp;
	} caa_cfg_t;

endpackage
`default_nettype wire

/* src/caa_in_if.sv */
// Input word channel of the annunciator.
`default_nettype none
interface caa_in_if;
	import caa_pkg::*;
	logic                     valid;
	logic                     ready;
	action_t                  action;
	logic signed [TEMP_W-1:0] coolant_temp;
	logic                     bus_error;
	logic                     cycle_active;

	modport source (output valid, action, coolant_temp, bus_error, cycle_active, input ready);
	modport sink (input valid, action, coolant_temp, bus_error, cycle_active, output ready);
endinterface
`default_nettype wire

/* src/caa_out_if.sv */
// Result word channel of the annunciator.
`default_nettype none
interface caa_out_if;
	import caa_pkg::*;
	logic              valid;
	logic              ready;
	logic              buzzer_on;
	logic [TONE_W-1:0] tone_hz;
	logic              led_on;

	modport source (output valid, buzzer_on, tone_hz, led_on, input ready);
	modport sink (input valid, buzzer_on, tone_hz, led_on, output ready);
endinterface
`default_nettype wire

/* src/caa_step.sv */
// Next-state logic of the annunciator for one input word.
`default_nettype none
module caa_step (
	input  caa_pkg::caa_state_t cur,
	input  caa_pkg::caa_item_t  item,
	input  caa_pkg::caa_cfg_t   cfg,
	output caa_pkg::caa_state_t nxt
);
	import caa_pkg::*;

	logic signed [TEMP_W+1:0] t_x, w_x, f_x;

	assign t_x = (TEMP_W+2)'(item.coolant_temp);
	assign w_x = (TEMP_W+2)'(cfg.warmup_temp);
	assign f_x = (TEMP_W+2)'(cfg.fan_temp);

	always_comb begin
		caa_state_t        s;
		logic [2:0]        beep_n;
		logic [TONE_W-1:0] beep_hz;
		logic [5:0]        beep_pause;
		s          = cur;
		beep_n     = 3'd2;
		beep_hz    = TONE_DOUBLE;
		beep_pause = WAIT_DOUBLE_PAUSE;
		unique case (item.action)
			ACT_TICK: begin
				if (item.cycle_active) begin
					// classify
					if (item.bus_error) begin
						s.sound_mode = SND_BUS_ERR;
					end else if (!(s.sound_mode == SND_CHIME || s.sound_mode == SND_START ||
							s.led_mode == LED_SINGLE)) begin
						if (t_x < w_x) begin
							s.sound_mode = SND_SILENT; s.led_mode = LED_STEADY;
						end else if (t_x < f_x - 11'sd6) begin
							s.sound_mode = SND_SILENT; s.led_mode = LED_OFF;
						end else if (t_x >= f_x - 11'sd3 && t_x < f_x) begin
							s.sound_mode = SND_SILENT; s.led_mode = LED_BLINK;
						end else if (t_x == f_x) begin
							s.sound_mode = SND_SINGLE; s.led_mode = LED_BLINK;
						end else if (t_x == f_x + 11'sd1) begin
							s.sound_mode = SND_DOUBLE; s.led_mode = LED_BLINK;
						end else if (t_x > f_x + 11'sd1) begin
							s.sound_mode = SND_TRIPLE; s.led_mode = LED_STEADY;
						end else begin
							s.sound_mode = SND_SILENT; s.led_mode = LED_OFF;
						end
					end
					// warm-up chime on a rise onto the warm-up value
					if (cur.prev_temp < cfg.warmup_temp && item.coolant_temp == cfg.warmup_temp)
						s.sound_mode = SND_CHIME;
					s.prev_temp = item.coolant_temp;

					// pattern shape for the double and triple beep modes, from the mode just chosen
					if (s.sound_mode == SND_TRIPLE) begin
						beep_n     = 3'd3;
						beep_hz    = TONE_TRIPLE;
						beep_pause = WAIT_TRIPLE_PAUSE;
					end

					// sound pattern step
					if (s.sound_mode != SND_SILENT && s.sound_wait != 6'd0) begin
						s.sound_wait = s.sound_wait - 6'd1;
					end else begin
						unique case (s.sound_mode)
							SND_SINGLE: begin
								if (!s.buzzer) begin
									s.buzzer = 1'b1; s.tone = TONE_SINGLE; s.sound_wait = WAIT_BEEP;
								end else begin
									s.buzzer = 1'b0; s.tone = '0; s.sound_wait = WAIT_SINGLE_PAUSE;
								end
							end
							SND_DOUBLE, SND_TRIPLE: begin
								if (!s.buzzer && s.pulse_index >= 3'd1 && s.pulse_index <= beep_n) begin
									s.buzzer = 1'b1; s.tone = beep_hz; s.sound_wait = WAIT_BEEP;
								end else if (s.buzzer && s.pulse_index >= 3'd1 &&
										s.pulse_index < beep_n) begin
									s.buzzer = 1'b0; s.tone = '0; s.sound_wait = WAIT_GAP;
									s.pulse_index = s.pulse_index + 3'd1;
								end else begin
									s.buzzer = 1'b0; s.tone = '0; s.sound_wait = beep_pause;
									s.pulse_index = 3'd1;
								end
							end
							SND_BUS_ERR: begin
								if (!s.buzzer) begin
									s.buzzer = 1'b1; s.tone = TONE_BUS_ERR; s.sound_wait = WAIT_ERR_BEEP;
								end else begin
									s.buzzer = 1'b0; s.tone = '0; s.sound_wait = WAIT_ERR_PAUSE;
								end
							end
							SND_CHIME: begin
								if (!s.buzzer) begin
									s.buzzer = 1'b1; s.tone = TONE_CHIME1; s.sound_wait = WAIT_BEEP;
									s.pulse_index = 3'd2;
								end else if (s.pulse_index == 3'd2) begin
									s.tone = TONE_CHIME2; s.sound_wait = WAIT_BEEP;
									s.pulse_index = 3'd3;
								end else if (s.pulse_index == 3'd3) begin
									s.tone = TONE_CHIME3; s.sound_wait = WAIT_BEEP;
									s.pulse_index = 3'd4;
								end else begin
									s.buzzer = 1'b0; s.tone = '0; s.pulse_index = 3'd1;
									s.sound_mode = SND_SILENT;
								end
							end
							SND_START: begin
								if (!s.buzzer) begin
									s.buzzer = 1'b1; s.tone = TONE_START; s.sound_wait = WAIT_BEEP;
								end else begin
									s.buzzer = 1'b0; s.tone = '0; s.sound_mode = SND_SILENT;
								end
							end
							default: begin
								s.buzzer = 1'b0; s.tone = '0;
							end
						endcase
					end

					// LED pattern step
					unique case (s.led_mode)
						LED_BLINK: begin
							if (s.led_wait != 4'd0) begin
								s.led_wait = s.led_wait - 4'd1;
							end else begin
								s.led = ~s.led; s.led_wait = LED_HALF_PERIOD;
							end
						end
						LED_STEADY: s.led = 1'b1;
						LED_SINGLE: begin
							if (s.led_wait != 4'd0) begin
								s.led_wait = s.led_wait - 4'd1;
							end else if (!s.led) begin
								s.led = 1'b1; s.led_wait = LED_FLASH;
							end else begin
								s.led = 1'b0; s.led_mode = LED_OFF;
							end
						end
						default: s.led = 1'b0;
					endcase
				end
			end
			ACT_START: s.sound_mode = SND_START;
			ACT_BLINK: begin
				if (s.led_mode == LED_OFF) s.led_mode = LED_SINGLE;
			end
			default: begin
				s.sound_mode = SND_SILENT; s.led_mode = LED_OFF;
				s.buzzer = 1'b0; s.tone = '0; s.led = 1'b0;
			end
		endcase
		nxt = s;
	end
endmodule
`default_nettype wire

/* src/coolant_alarm_annunciator_unit.sv */
// Top level of the coolant alarm annunciator: input stage, state, result stage, APB registers.
`default_nettype none
// The annunciator takes one word per clock while its results are taken. A word
// goes into an input register, is applied to the buzzer/LED state by the
// next-state logic, and its result lands in the result register once the result
// slot is free, where it is held until taken. Sustained rate is one word per
// cycle while no result stalls, set by the combinational state update between the
// two registers; the input side keeps accepting while a result waits, as long as
// the input register is empty or can hand its word on. Every word returns exactly
// one result: the buzzer level, the tone frequency in Hz (0 when silent) and the
// LED level after that word. The warm-up and fan temperatures sit at APB byte
// addresses 0 and 4 (9-bit signed, read back sign-extended); write them only
// while no word is in flight.
module coolant_alarm_annunciator_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	caa_in_if.sink                         din,
	caa_out_if.source                      dout,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [caa_pkg::ADDR_W-1:0]     paddr,
	input  wire  [caa_pkg::DATA_W-1:0]     pwdata,
	output logic [caa_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import caa_pkg::*;

	caa_cfg_t   cfg_q;
	caa_state_t state_q;
	caa_state_t state_nxt;
	caa_item_t  item_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       buzzer_s2;
	logic [TONE_W-1:0] tone_s2;
	logic       led_s2;
	logic       advance_s1;
	logic       cfg_wr;
	reg_idx_t   cfg_sel;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign cfg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_temp <= WARMUP_RESET;
			cfg_q.fan_temp    <= FAN_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_WARMUP: cfg_q.warmup_temp <= $signed(pwdata[TEMP_W-1:0]);
				REG_FAN:    cfg_q.fan_temp    <= $signed(pwdata[TEMP_W-1:0]);
				default:    ;
			endcase
		end
	end

	// read back sign-extended
	always_comb begin
		unique case (cfg_sel)
			REG_FAN: prdata = DATA_W'(cfg_q.fan_temp);
			default: prdata = DATA_W'(cfg_q.warmup_temp);
		endcase
	end

	// ---- handshake: input register hands on when the result slot is free ----
	assign advance_s1 = valid_s1 && (!valid_s2 || dout.ready);
	assign din.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	// capture the incoming word; payload needs no reset
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			item_s1.action       <= din.action;
			item_s1.coolant_temp <= din.coolant_temp;
			item_s1.bus_error    <= din.bus_error;
			item_s1.cycle_active <= din.cycle_active;
		end
	end

	// ---- state update ----
	caa_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt)
	);

	// advance the annunciator state once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.sound_mode  <= SND_SILENT;
			state_q.led_mode    <= LED_OFF;
			state_q.pulse_index <= 3'd1;
			state_q.sound_wait  <= '0;
			state_q.led_wait    <= '0;
			state_q.prev_temp   <= '0;
			state_q.buzzer      <= 1'b0;
			state_q.tone        <= '0;
			state_q.led         <= 1'b0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (dout.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			buzzer_s2 <= state_nxt.buzzer;
			tone_s2   <= state_nxt.tone;
			led_s2    <= state_nxt.led;
		end
	end

	assign dout.valid     = valid_s2;
	assign dout.buzzer_on = buzzer_s2;
	assign dout.tone_hz   = tone_s2;
	assign dout.led_on    = led_s2;

endmodule
`default_nettype wire

/* src/caa_checker.sv */
// Port-level checks for the annunciator and their binding to the top level.
`default_nettype none
module caa_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire                       buzzer_on,
	input wire [caa_pkg::TONE_W-1:0] tone_hz,
	input wire                       led_on
);
	import caa_pkg::*;

	// a tone sounds exactly when the buzzer is on
	a_tone_matches_buzzer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((tone_hz != '0) == buzzer_on))
		else $error("tone and buzzer level disagree");

	// only pattern frequencies appear
	a_tone_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tone_hz == '0 || tone_hz == TONE_SINGLE || tone_hz == TONE_DOUBLE ||
			tone_hz == TONE_TRIPLE || tone_hz == TONE_BUS_ERR || tone_hz == TONE_START ||
			tone_hz == TONE_CHIME1 || tone_hz == TONE_CHIME2 || tone_hz == TONE_CHIME3))
		else $error("unexpected tone frequency");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(buzzer_on) && $stable(tone_hz) &&
			$stable(led_on))
		else $error("stalled result changed");
endmodule

bind coolant_alarm_annunciator_unit caa_checker u_caa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.buzzer_on (dout.buzzer_on),
	.tone_hz   (dout.tone_hz),
	.led_on    (dout.led_on)
);
`default_nettype wire
